FILE: design/sifb_pkg.sv
// Shared types and constants for the single-input FIR filter bank.
`timescale 1ns / 1ps

package sifb_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int COEF_WIDTH    = 16;
  localparam int PROD_WIDTH    = 32;
  localparam int ACC_WIDTH     = 40;
  localparam int STRIDE_WIDTH  = 4;
  localparam int CHANNEL_WIDTH = 3;
  localparam int TAP_SEL_WIDTH = 6;
  localparam int MAX_CHANNELS  = 8;

  localparam logic [STRIDE_WIDTH-1:0] STRIDE_RESET = 4'd1;

  // item function codes
  localparam logic FUNC_COEF   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef struct packed {
    logic                            func;
    logic [CHANNEL_WIDTH-1:0]        filter_select;
    logic [TAP_SEL_WIDTH-1:0]        tap_select;
    logic signed [COEF_WIDTH-1:0]    coef_value;
    logic signed [SAMPLE_WIDTH-1:0]  sample_value;
  } sifb_item_t;

  typedef struct packed {
    logic [CHANNEL_WIDTH-1:0]        channel;
    logic signed [ACC_WIDTH-1:0]     filtered_value;
    logic                            last;
  } sifb_result_t;

  // controller -> datapath / output buffer
  typedef struct packed {
    logic coef_we;
    logic sample_we;
    logic issue;
    logic load;
  } sifb_cmd_t;

  // datapath / output buffer -> controller
  typedef struct packed {
    logic pipe_busy;
    logic out_busy;
  } sifb_status_t;

endpackage

FILE: design/single_input_fir_filter_bank.sv
// Top level of the single-input FIR filter bank.
`timescale 1ns / 1ps

// A bank of up to eight FIR filters fed from one sample stream. An item with
// func = coefficient stores one Q1.15 tap without holding off the input; an
// item with func = sample writes the sample into a circular delay line of
// BUFFER_DEPTH entries and then runs every filter over NUM_TAPS delay-line
// samples, newest first, spaced tap_stride entries apart. All filters run in
// parallel, one tap per cycle, through a registered memory read, a registered
// 16x16 multiply and a 40-bit accumulate. Once a sample item is accepted, the
// input is held off while NUM_TAPS taps step through the shared delay-line
// read port, the multiply pipe drains and the sums go to the output buffer;
// besides the drain, that hand-over waits only if the previous sample's
// results have not all been taken. The sums then leave as one item per filter
// in filter order, last flagged on the final one, while the next items are
// already taken. Delay-line entries never written since reset read as zero
// (tracked by a fill mark, no clearing pass). Coefficients read before they
// were written give undefined sums. The user writes tap_stride through
// cfg_write_en / cfg_write_data only while idle; the block does not enforce it.
module single_input_fir_filter_bank #(
  parameter int NUM_FILTERS  = 8,
  parameter int NUM_TAPS     = 64,
  parameter int BUFFER_DEPTH = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  // item channel
  input  logic                              item_valid,
  output logic                              item_stall,
  input  sifb_pkg::sifb_item_t              item,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output sifb_pkg::sifb_result_t            result,
  // tap_stride register
  input  logic                              cfg_write_en,
  input  logic [sifb_pkg::STRIDE_WIDTH-1:0] cfg_write_data
);

  // filter_select is three bits wide, so at most eight filters are reachable
  localparam int LANES = (NUM_FILTERS < sifb_pkg::MAX_CHANNELS) ?
                         NUM_FILTERS : sifb_pkg::MAX_CHANNELS;
  localparam int TW    = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;

  sifb_pkg::sifb_cmd_t    cmd;
  sifb_pkg::sifb_status_t status;
  logic [TW-1:0]          tap_addr;
  logic                   pipe_busy;
  logic                   out_busy;
  logic signed [sifb_pkg::ACC_WIDTH-1:0] acc [LANES];

  assign status.pipe_busy = pipe_busy;
  assign status.out_busy  = out_busy;

  sifb_ctrl #(
    .NUM_TAPS (NUM_TAPS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_func  (item.func),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd),
    .tap_addr   (tap_addr)
  );

  sifb_dp #(
    .NUM_TAPS     (NUM_TAPS),
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .LANES        (LANES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .tap_addr       (tap_addr),
    .item           (item),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .pipe_busy      (pipe_busy),
    .acc            (acc)
  );

  sifb_outbuf #(
    .LANES (LANES)
  ) u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .load         (cmd.load),
    .acc          (acc),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .out_busy     (out_busy)
  );

endmodule

FILE: design/sifb_ctrl.sv
// Sequencer: accepts items, steps the tap address, hands sums to the output buffer.
`timescale 1ns / 1ps

module sifb_ctrl #(
  parameter int NUM_TAPS = 64,
  localparam int TW = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_func,
  output logic                 item_stall,
  input  sifb_pkg::sifb_status_t status,
  output sifb_pkg::sifb_cmd_t  cmd,
  output logic [TW-1:0]        tap_addr
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam logic [TW-1:0] TAP_LAST = TW'(NUM_TAPS - 1);

  logic [1:0]    state, state_next;
  logic [TW-1:0] tap_addr_next;

  always_comb begin
    state_next    = state;
    tap_addr_next = tap_addr;
    cmd           = '0;
    item_stall    = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (item_func == sifb_pkg::FUNC_SAMPLE) begin
            cmd.sample_we = 1'b1;
            tap_addr_next = '0;
            state_next    = ST_RUN;
          end else begin
            cmd.coef_we = 1'b1;
          end
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (tap_addr == TAP_LAST) begin
          state_next = ST_DRAIN;
        end else begin
          tap_addr_next = tap_addr + TW'(1);
        end
      end
      ST_DRAIN: begin
        // wait for the MAC pipe to empty and the previous sums to be taken
        if (!status.pipe_busy && !status.out_busy) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      tap_addr <= '0;
    end else begin
      state    <= state_next;
      tap_addr <= tap_addr_next;
    end
  end

endmodule

FILE: design/sifb_dp.sv
// Datapath: delay line, per-filter coefficient memories and multiply-accumulate lanes.
`timescale 1ns / 1ps

module sifb_dp #(
  parameter int NUM_TAPS     = 64,
  parameter int BUFFER_DEPTH = 512,
  parameter int LANES        = 8,
  localparam int TW = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1,
  localparam int BW = $clog2(BUFFER_DEPTH)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  sifb_pkg::sifb_cmd_t                    cmd,
  input  logic [TW-1:0]                          tap_addr,
  input  sifb_pkg::sifb_item_t                   item,
  input  logic                                   cfg_write_en,
  input  logic [sifb_pkg::STRIDE_WIDTH-1:0]      cfg_write_data,
  output logic                                   pipe_busy,
  output logic signed [sifb_pkg::ACC_WIDTH-1:0]  acc [LANES]
);

  localparam int SW  = sifb_pkg::SAMPLE_WIDTH;
  localparam int CWD = sifb_pkg::COEF_WIDTH;
  localparam int PW  = sifb_pkg::PROD_WIDTH;
  localparam int AW  = sifb_pkg::ACC_WIDTH;
  localparam int STW = sifb_pkg::STRIDE_WIDTH;
  localparam int CHW = sifb_pkg::CHANNEL_WIDTH;

  localparam logic [BW-1:0] POS_LAST = BW'(BUFFER_DEPTH - 1);
  localparam logic [BW:0]   DEPTH_X  = (BW+1)'(BUFFER_DEPTH);

  logic [STW-1:0] stride;
  logic [BW-1:0]  wp, head, pos, pos_next;
  logic           filled;
  logic [BW:0]    pos_x, step_x;

  logic signed [SW-1:0] dline [BUFFER_DEPTH];
  logic signed [SW-1:0] sample_q, sample_eff;
  logic                 sample_ok;
  logic                 rd_vld, mul_vld;
  logic                 tap_ok;

  // newest-first walk back through the ring
  always_comb begin
    pos_x  = {1'b0, pos};
    step_x = (BW+1)'(stride);
    if (pos_x >= step_x) begin
      pos_next = BW'(pos_x - step_x);
    end else begin
      pos_next = BW'(pos_x + DEPTH_X - step_x);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stride  <= sifb_pkg::STRIDE_RESET;
      wp      <= '0;
      head    <= '0;
      pos     <= '0;
      filled  <= 1'b0;
      rd_vld  <= 1'b0;
      mul_vld <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        stride <= cfg_write_data;
      end
      if (cmd.sample_we) begin
        head <= wp;
        pos  <= wp;
        wp   <= (wp == POS_LAST) ? '0 : wp + BW'(1);
        if (wp == POS_LAST) begin
          filled <= 1'b1;
        end
      end else if (cmd.issue) begin
        pos <= pos_next;
      end
      rd_vld  <= cmd.issue;
      mul_vld <= rd_vld;
    end
  end

  // delay line: entries past the fill point read as zero until written once
  always_ff @(posedge clk) begin
    if (cmd.sample_we) begin
      dline[wp] <= item.sample_value;
    end
    if (cmd.issue) begin
      sample_q  <= dline[pos];
      sample_ok <= filled || (pos <= head);
    end
  end

  assign sample_eff = sample_ok ? sample_q : '0;
  assign pipe_busy  = rd_vld | mul_vld;
  assign tap_ok     = (32'(item.tap_select) < NUM_TAPS);

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic signed [CWD-1:0] cmem [NUM_TAPS];
    logic signed [CWD-1:0] coef_q;
    logic signed [PW-1:0]  prod;
    logic                  sel;

    assign sel = cmd.coef_we && tap_ok && (item.filter_select == CHW'(g));

    always_ff @(posedge clk) begin
      if (sel) begin
        cmem[TW'(item.tap_select)] <= item.coef_value;
      end
      if (cmd.issue) begin
        coef_q <= cmem[tap_addr];
      end
    end

    always_ff @(posedge clk) begin
      if (rd_vld) begin
        prod <= coef_q * sample_eff;
      end
      if (cmd.sample_we) begin
        acc[g] <= '0;
      end else if (mul_vld) begin
        acc[g] <= acc[g] + {{(AW-PW){prod[PW-1]}}, prod};
      end
    end
  end

endmodule

FILE: design/sifb_outbuf.sv
// Output buffer: holds one sample's sums and shifts them out one item per filter.
`timescale 1ns / 1ps

module sifb_outbuf #(
  parameter int LANES = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load,
  input  logic signed [sifb_pkg::ACC_WIDTH-1:0]  acc [LANES],
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output sifb_pkg::sifb_result_t                 result,
  output logic                                   out_busy
);

  localparam int AW  = sifb_pkg::ACC_WIDTH;
  localparam int CHW = sifb_pkg::CHANNEL_WIDTH;
  localparam logic [CHW-1:0] CH_LAST = CHW'(LANES - 1);

  logic signed [AW-1:0] res [LANES];
  logic [CHW-1:0]       idx;
  logic                 busy;
  logic                 take;
  logic                 is_last;

  assign take    = busy && !result_stall;
  assign is_last = (idx == CH_LAST);

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < LANES; i++) begin
        res[i] <= acc[i];
      end
    end else if (take) begin
      for (int i = 0; i < LANES - 1; i++) begin
        res[i] <= res[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + CHW'(1);
      end
    end
  end

  always_comb begin
    result.channel        = idx;
    result.filtered_value = res[0];
    result.last           = is_last;
  end

  assign result_valid = busy;
  assign out_busy     = busy;

endmodule

FILE: design/sifb_checker.sv
// Port-level checks for the filter bank, bound to the top level.
`timescale 1ns / 1ps

module sifb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              item_valid,
  input logic                              item_stall,
  input sifb_pkg::sifb_item_t              item,
  input logic                              result_valid,
  input logic                              result_stall,
  input sifb_pkg::sifb_result_t            result,
  input logic                              cfg_write_en,
  input logic [sifb_pkg::STRIDE_WIDTH-1:0] cfg_write_data
);

  logic item_take, result_take;

  assign item_take   = item_valid && !item_stall;
  assign result_take = result_valid && !result_stall;

  // a stalled result item stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result item changed while stalled");

  // channels of one sample come out back to back in order
  a_channel_seq: assert property (@(posedge clk) disable iff (rst)
    result_take && !result.last |=>
      result_valid && (result.channel == 3'($past(result.channel) + 3'd1)))
    else $error("result channel out of sequence");

  // a new set of sums never appears in the cycle right after the last item
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_take && result.last |=> !result_valid)
    else $error("result valid directly after last item");

  // a sample item starts the filter run and holds off the input
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    item_take && (item.func == sifb_pkg::FUNC_SAMPLE) |=> item_stall)
    else $error("input not stalled during filter run");

  // a coefficient write does not hold off the input
  a_coef_fast: assert property (@(posedge clk) disable iff (rst)
    item_take && (item.func == sifb_pkg::FUNC_COEF) |=> !item_stall)
    else $error("input stalled after coefficient write");

endmodule

bind single_input_fir_filter_bank sifb_checker u_checker (.*);
